// ===== hdl/tppq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppq_pkg
// Shared types, widths and register indexes of the triangle point/plane
// query core.
// ----------------------------------------------------------------------------
package tppq_pkg;

	// Coordinate width and the widths that follow from it
	localparam int COORD_BITS = 16;
	localparam int DW = COORD_BITS + 1;        // vertex difference
	localparam int CW = 2 * DW + 1;            // cross product component
	localparam int PW = CW + DW;               // normal x offset product
	localparam int SW = PW + 2;                // raw side value
	localparam int EW = 2 * CW;                // cross x cross product
	localparam int LW = EW + 2;                // normal length squared
	localparam int TW = LW + 1;                // edge test sum with tolerance
	localparam int MW = SW;                    // side magnitude
	localparam int HW = (MW + 1) / 2;          // low half of magnitude
	localparam int HIW = MW - HW;              // high half of magnitude
	localparam int QW = 2 * MW;                // side squared
	localparam int NW = QW + 2;                // rounding numerator
	localparam int DNW = LW + 1;               // rounding denominator
	localparam int QB = 40;                    // quotient bits
	localparam int XW = (NW > DNW + QB) ? NW : DNW + QB;

	// Fixed field widths
	localparam int SIDE_W = 52;
	localparam int SDIST_W = 41;
	localparam int DIST_W = 40;
	localparam int TOL_W = 16;
	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INSIDE_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGENERATE_DISTANCE = 1'd1;

	typedef struct packed {
		logic [COORD_BITS-1:0] a_x;
		logic [COORD_BITS-1:0] a_y;
		logic [COORD_BITS-1:0] a_z;
		logic [COORD_BITS-1:0] b_x;
		logic [COORD_BITS-1:0] b_y;
		logic [COORD_BITS-1:0] b_z;
		logic [COORD_BITS-1:0] c_x;
		logic [COORD_BITS-1:0] c_y;
		logic [COORD_BITS-1:0] c_z;
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
		logic [COORD_BITS-1:0] point_z;
	} query_t;

	typedef struct packed {
		logic [SIDE_W-1:0] side_value;
		logic [SDIST_W-1:0] signed_sq_distance;
		logic [DIST_W-1:0] abs_sq_distance;
		logic inside_res;
		logic degenerate;
	} result_t;

	// Side information that rides along with the divider
	typedef struct packed {
		logic [SIDE_W-1:0] side;
		logic neg;
		logic degen;
		logic in_tri;
	} tag_t;

	// Sign-extended difference of two coordinates
	function automatic logic signed [DW-1:0] coord_sub(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic signed [DW-1:0] ea;
		logic signed [DW-1:0] eb;
		ea = $signed({a[COORD_BITS-1], a});
		eb = $signed({b[COORD_BITS-1], b});
		return ea - eb;
	endfunction

endpackage

// ===== hdl/tppq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppq_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow check for quotients that do not fit in QB bits.
// ----------------------------------------------------------------------------
module tppq_div
	import tppq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DNW-1:0] in_den,
	input  tag_t in_tag,
	output logic out_valid,
	output logic [QB-1:0] out_quo,
	output logic out_ovf,
	output tag_t out_tag
);

	logic vld_sk [QB+1];
	logic [NW-1:0] rem_sk [QB+1];
	logic [DNW-1:0] den_sk [QB+1];
	logic [QB-1:0] quo_sk [QB+1];
	logic ovf_sk [QB+1];
	tag_t tag_sk [QB+1];

	// Entry stage: quotient overflow when num >= den * 2^QB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else begin
			vld_sk[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_sk[0] <= in_num;
		den_sk[0] <= in_den;
		quo_sk[0] <= '0;
		ovf_sk[0] <= XW'(in_num) >= (XW'(in_den) << QB);
		tag_sk[0] <= in_tag;
	end

	// One quotient bit per stage, MSB first
	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int J = QB - 1 - k;
		logic [XW:0] diff;
		logic take;

		assign diff = {1'b0, XW'(rem_sk[k])} - {1'b0, (XW'(den_sk[k]) << J)};
		assign take = !diff[XW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_sk[k+1] <= take ? NW'(diff) : rem_sk[k];
			den_sk[k+1] <= den_sk[k];
			quo_sk[k+1] <= {quo_sk[k][QB-2:0], take};
			ovf_sk[k+1] <= ovf_sk[k];
			tag_sk[k+1] <= tag_sk[k];
		end
	end

	assign out_valid = vld_sk[QB];
	assign out_quo = quo_sk[QB];
	assign out_ovf = ovf_sk[QB];
	assign out_tag = tag_sk[QB];

endmodule

// ===== hdl/triangle_point_plane_query_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_point_plane_query_core
// Plane side value, rounded squared plane distance and prism inside test
// for one triangle and one point per transfer.
// ----------------------------------------------------------------------------
// Channel   Ports                          Transfer
// query     start, busy, query             start high, busy low
// result    done, result                   done high, one cycle, no stall
// config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// One transfer may be taken in every cycle; busy stays low.
// A result passes through eight arithmetic stages, 41 divider stages (an
// entry stage, then one quotient bit each) and the output register.
// Reset clears the valid bits and loads the register defaults.
// The receiver takes every result, so nothing ever stalls.
// ----------------------------------------------------------------------------
module triangle_point_plane_query_core
	import tppq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  query_t query,
	output logic done,
	output result_t result,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// Configuration registers
	logic [TOL_W-1:0] tol_q;
	logic [DIST_W-1:0] degdist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
			degdist_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INSIDE_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
				REG_DEGENERATE_DISTANCE: degdist_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Stage 1: vertex differences
	logic [COORD_BITS-1:0] vtx [3][3];
	logic [COORD_BITS-1:0] pnt [3];
	logic signed [DW-1:0] e0_s1 [3];
	logic signed [DW-1:0] e1_s1 [3];
	logic signed [DW-1:0] r_s1 [3];
	logic signed [DW-1:0] a0_s1 [3][3];
	logic signed [DW-1:0] pp_s1 [3][3];

	always_comb begin
		vtx[0][0] = query.a_x;
		vtx[0][1] = query.a_y;
		vtx[0][2] = query.a_z;
		vtx[1][0] = query.b_x;
		vtx[1][1] = query.b_y;
		vtx[1][2] = query.b_z;
		vtx[2][0] = query.c_x;
		vtx[2][1] = query.c_y;
		vtx[2][2] = query.c_z;
		pnt[0] = query.point_x;
		pnt[1] = query.point_y;
		pnt[2] = query.point_z;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e0_s1[k] <= coord_sub(vtx[1][k], vtx[0][k]);
			e1_s1[k] <= coord_sub(vtx[2][k], vtx[0][k]);
			r_s1[k] <= coord_sub(pnt[k], vtx[0][k]);
			for (int i = 0; i < 3; i++) begin
				a0_s1[i][k] <= coord_sub(vtx[(i + 1) % 3][k], vtx[i][k]);
				pp_s1[i][k] <= coord_sub(pnt[k], vtx[i][k]);
			end
		end
	end

	// Stage 2: cross products. r0 is the face normal shared by all edges;
	// the plane normal is its negation.
	logic signed [CW-1:0] r0_s2 [3];
	logic signed [CW-1:0] r1_s2 [3][3];
	logic signed [DW-1:0] rr_s2 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			r0_s2[k] <= CW'(e0_s1[(k + 1) % 3]) * CW'(e1_s1[(k + 2) % 3])
				- CW'(e0_s1[(k + 2) % 3]) * CW'(e1_s1[(k + 1) % 3]);
			rr_s2[k] <= r_s1[k];
			for (int i = 0; i < 3; i++) begin
				r1_s2[i][k] <= CW'(a0_s1[i][(k + 1) % 3]) * CW'(pp_s1[i][(k + 2) % 3])
					- CW'(a0_s1[i][(k + 2) % 3]) * CW'(pp_s1[i][(k + 1) % 3]);
			end
		end
	end

	// Stage 3: dot product terms
	logic signed [PW-1:0] pd_s3 [3];
	logic signed [EW-1:0] pl_s3 [3];
	logic signed [EW-1:0] pe_s3 [3][3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pd_s3[k] <= PW'(r0_s2[k]) * PW'(rr_s2[k]);
			pl_s3[k] <= EW'(r0_s2[k]) * EW'(r0_s2[k]);
			for (int i = 0; i < 3; i++) begin
				pe_s3[i][k] <= EW'(r0_s2[k]) * EW'(r1_s2[i][k]);
			end
		end
	end

	// Stage 4: sums; edge sums take the tolerance
	logic signed [SW-1:0] d_s4;
	logic signed [LW-1:0] l_s4;
	logic signed [TW-1:0] t_s4 [3];

	always_ff @(posedge clk) begin
		d_s4 <= -(SW'(pd_s3[0]) + SW'(pd_s3[1]) + SW'(pd_s3[2]));
		l_s4 <= LW'(pl_s3[0]) + LW'(pl_s3[1]) + LW'(pl_s3[2]);
		for (int i = 0; i < 3; i++) begin
			t_s4[i] <= TW'(pe_s3[i][0]) + TW'(pe_s3[i][1]) + TW'(pe_s3[i][2])
				+ TW'($signed({1'b0, tol_q}));
		end
	end

	// Stage 5: magnitude, degenerate flag, inside decision
	logic [MW-1:0] mag_s5;
	logic [LW-1:0] l_s5;
	tag_t tag_s5;
	logic [2:0] edge_ok;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			edge_ok[i] = !t_s4[i][TW-1] && (|t_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		mag_s5 <= d_s4[SW-1] ? MW'(-d_s4) : MW'(d_s4);
		l_s5 <= l_s4;
		tag_s5.side <= SIDE_W'(d_s4);
		tag_s5.neg <= d_s4[SW-1];
		tag_s5.degen <= (l_s4 == '0);
		tag_s5.in_tri <= &edge_ok;
	end

	// Stage 6: partial products of the magnitude squared
	logic [HIW-1:0] mag_hi;
	logic [HW-1:0] mag_lo;
	logic [2*HIW-1:0] hh_s6;
	logic [HIW+HW-1:0] hl_s6;
	logic [2*HW-1:0] ll_s6;
	logic [LW-1:0] l_s6;
	tag_t tag_s6;

	assign mag_hi = mag_s5[MW-1:HW];
	assign mag_lo = mag_s5[HW-1:0];

	always_ff @(posedge clk) begin
		hh_s6 <= (2 * HIW)'(mag_hi) * (2 * HIW)'(mag_hi);
		hl_s6 <= (HIW + HW)'(mag_hi) * (HIW + HW)'(mag_lo);
		ll_s6 <= (2 * HW)'(mag_lo) * (2 * HW)'(mag_lo);
		l_s6 <= l_s5;
		tag_s6 <= tag_s5;
	end

	// Stage 7: combine partial products
	logic [QW-1:0] sq_s7;
	logic [LW-1:0] l_s7;
	tag_t tag_s7;

	always_ff @(posedge clk) begin
		sq_s7 <= (QW'(hh_s6) << (2 * HW)) + (QW'(hl_s6) << (HW + 1)) + QW'(ll_s6);
		l_s7 <= l_s6;
		tag_s7 <= tag_s6;
	end

	// Stage 8: round to nearest as floor((2*sq + l) / (2*l))
	logic [NW-1:0] num_s8;
	logic [DNW-1:0] den_s8;
	tag_t tag_s8;

	always_ff @(posedge clk) begin
		num_s8 <= (NW'(sq_s7) << 1) + NW'(l_s7);
		den_s8 <= DNW'(l_s7) << 1;
		tag_s8 <= tag_s7;
	end

	// Divider
	logic div_vld;
	logic [QB-1:0] div_quo;
	logic div_ovf;
	tag_t div_tag;

	tppq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s8),
		.in_num   (num_s8),
		.in_den   (den_s8),
		.in_tag   (tag_s8),
		.out_valid(div_vld),
		.out_quo  (div_quo),
		.out_ovf  (div_ovf),
		.out_tag  (div_tag)
	);

	// Output register: saturate, apply sign, pick degenerate value
	logic [DIST_W-1:0] sq_dist;
	logic [SDIST_W-1:0] sdist;
	logic done_q;
	result_t res_q;

	always_comb begin
		if (div_tag.degen) begin
			sq_dist = degdist_q;
			sdist = {1'b0, degdist_q};
		end else begin
			sq_dist = div_ovf ? '1 : DIST_W'(div_quo);
			sdist = div_tag.neg ? (SDIST_W'(0) - {1'b0, sq_dist}) : {1'b0, sq_dist};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q.side_value <= div_tag.side;
		res_q.signed_sq_distance <= sdist;
		res_q.abs_sq_distance <= sq_dist;
		res_q.inside_res <= div_tag.in_tri;
		res_q.degenerate <= div_tag.degen;
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ===== sim/triangle_point_plane_query_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_point_plane_query_core_test
// Self-checking bench for the triangle point/plane query core. Directed
// corner cases, then random triangles and points in several idle phases and
// register settings, each result checked against an exact integer predictor.
// ----------------------------------------------------------------------------
module triangle_point_plane_query_core_test;
	import tppq_pkg::*;

	localparam int LATENCY = 49;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	query_t query;
	logic done;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// predictor copy of the registers
	logic [TOL_W-1:0] tol_q;
	logic [DIST_W-1:0] degen_dist_q;

	query_t pending_q[$];
	result_t expected_q[$];
	int idle_pct;
	int mismatches;
	int checked;
	int degen_seen;
	int inside_seen;

	triangle_point_plane_query_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .query(query),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Exact prediction of one query
	function automatic result_t predict_query(query_t q);
		logic signed [255:0] v[3][3];
		logic signed [255:0] p[3];
		logic signed [255:0] e0[3], e1[3], n[3], r[3], a0[3], a1[3], pp[3], r0[3], r1[3];
		logic signed [255:0] side, len, mag, t;
		logic [255:0] quo;
		logic [DIST_W-1:0] sq_dist;
		result_t res;
		logic in_all;
		int i, i1, i2;
		v[0][0] = $signed(q.a_x); v[0][1] = $signed(q.a_y); v[0][2] = $signed(q.a_z);
		v[1][0] = $signed(q.b_x); v[1][1] = $signed(q.b_y); v[1][2] = $signed(q.b_z);
		v[2][0] = $signed(q.c_x); v[2][1] = $signed(q.c_y); v[2][2] = $signed(q.c_z);
		p[0] = $signed(q.point_x); p[1] = $signed(q.point_y); p[2] = $signed(q.point_z);
		for (int k = 0; k < 3; k++) begin
			e0[k] = v[1][k] - v[0][k];
			e1[k] = v[0][k] - v[2][k];
			r[k] = p[k] - v[0][k];
		end
		n[0] = e0[1] * e1[2] - e0[2] * e1[1];
		n[1] = e0[2] * e1[0] - e0[0] * e1[2];
		n[2] = e0[0] * e1[1] - e0[1] * e1[0];
		side = n[0] * r[0] + n[1] * r[1] + n[2] * r[2];
		len = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
		res.side_value = side[SIDE_W-1:0];
		res.degenerate = (len == 0);
		if (len == 0) begin
			res.abs_sq_distance = degen_dist_q;
			res.signed_sq_distance = {1'b0, degen_dist_q};
		end else begin
			mag = (side < 0) ? -side : side;
			// round to nearest, ties up
			quo = (2 * mag * mag + len) / (2 * len);
			sq_dist = (quo > 256'hFF_FFFF_FFFF) ? '1 : quo[DIST_W-1:0];
			res.abs_sq_distance = sq_dist;
			res.signed_sq_distance = (side < 0) ? -{1'b0, sq_dist} : {1'b0, sq_dist};
		end
		in_all = 1'b1;
		for (i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int k = 0; k < 3; k++) begin
				a0[k] = v[i1][k] - v[i][k];
				a1[k] = v[i2][k] - v[i][k];
				pp[k] = p[k] - v[i][k];
			end
			r0[0] = a0[1] * a1[2] - a0[2] * a1[1];
			r0[1] = a0[2] * a1[0] - a0[0] * a1[2];
			r0[2] = a0[0] * a1[1] - a0[1] * a1[0];
			r1[0] = a0[1] * pp[2] - a0[2] * pp[1];
			r1[1] = a0[2] * pp[0] - a0[0] * pp[2];
			r1[2] = a0[0] * pp[1] - a0[1] * pp[0];
			t = r0[0] * r1[0] + r0[1] * r1[1] + r0[2] * r1[2] + $signed({240'd0, tol_q});
			if (t <= 0)
				in_all = 1'b0;
		end
		res.inside_res = in_all;
		return res;
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
		case (mode)
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'($urandom_range(0, 40) - 20);
			default: return ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'h7FFF;
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int mode;
		mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
		q = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
		// collinear triangle now and then
		if ($urandom_range(0, 7) == 0) begin
			q.c_x = q.a_x; q.c_y = q.a_y; q.c_z = q.a_z;
		end
		// point placed at the triangle centroid now and then
		if ($urandom_range(0, 4) == 0) begin
			q.point_x = COORD_BITS'(($signed(q.a_x) + $signed(q.b_x) + $signed(q.c_x)) / 3);
			q.point_y = COORD_BITS'(($signed(q.a_y) + $signed(q.b_y) + $signed(q.c_y)) / 3);
			q.point_z = COORD_BITS'(($signed(q.a_z) + $signed(q.b_z) + $signed(q.c_z)) / 3);
		end
		return q;
	endfunction

	// Query driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n && pending_q.size() > 0 && ($urandom_range(0, 99) >= idle_pct)) begin
			start <= 1'b1;
			query <= pending_q[0];
		end else begin
			start <= 1'b0;
			query <= {6{$urandom}};
		end
	end

	// Transfer accounting and result check at the rising edge
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && start && !busy) begin
			expected_q.push_back(predict_query(pending_q[0]));
			void'(pending_q.pop_front());
		end
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				exp_res = expected_q.pop_front();
				checked++;
				if (result.degenerate)
					degen_seen++;
				if (result.inside_res)
					inside_seen++;
				if (result !== exp_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: side %h/%h sdist %h/%h dist %h/%h in %b/%b dg %b/%b",
							exp_res.side_value, result.side_value,
							exp_res.signed_sq_distance, result.signed_sq_distance,
							exp_res.abs_sq_distance, result.abs_sq_distance,
							exp_res.inside_res, result.inside_res,
							exp_res.degenerate, result.degenerate);
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_INSIDE_TOLERANCE)
			tol_q = val[TOL_W-1:0];
		else
			degen_dist_q = val[DIST_W-1:0];
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		query_t q;
		int phase_pct[4];
		phase_pct = '{0, 58, 0, 7};
		start = 1'b0;
		query = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		mismatches = 0;
		checked = 0;
		degen_seen = 0;
		inside_seen = 0;
		tol_q = '0;
		degen_dist_q = '1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n = 1'b1;

		// directed: simple inside, outside, on edge, degenerate, extremes
		q = '0;
		q.b_x = 16'd10; q.c_y = 16'd10; q.point_x = 16'd2; q.point_y = 16'd2;
		q.point_z = 16'd5;
		pending_q.push_back(q);
		q.point_z = -16'sd5; q.point_x = 16'd20;
		pending_q.push_back(q);
		q.point_x = 16'd5; q.point_y = 16'd0; q.point_z = 16'd0;
		pending_q.push_back(q);
		q.point_z = 16'd1;
		pending_q.push_back(q);
		pending_q.push_back('0);
		q = '0; q.b_x = 16'd4; q.c_x = 16'd8; q.point_y = 16'd3;
		pending_q.push_back(q);
		pending_q.push_back({12{16'h7FFF}});
		pending_q.push_back({12{16'h8000}});
		pending_q.push_back({16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
			16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
		pending_q.push_back({16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
			16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF});
		pending_q.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
			16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
		q = '0; q.b_x = 16'd3; q.c_y = 16'd3; q.point_z = 16'd1;
		pending_q.push_back(q);
		pending_q.push_back({12{16'hFFFF}});
		pending_q.push_back({12{16'h5555}});
		pending_q.push_back({12{16'hAAAA}});
		drain();

		// random phases over register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_INSIDE_TOLERANCE, 40'd0);
					write_reg(REG_DEGENERATE_DISTANCE, 40'd0); end
				1: begin write_reg(REG_INSIDE_TOLERANCE, 40'hFFFF);
					write_reg(REG_DEGENERATE_DISTANCE, 40'hFF_FFFF_FFFF); end
				2: begin write_reg(REG_INSIDE_TOLERANCE, 40'd1);
					write_reg(REG_DEGENERATE_DISTANCE, 40'h80_0000_0000); end
				default: begin write_reg(REG_INSIDE_TOLERANCE, CFG_W'($urandom));
					write_reg(REG_DEGENERATE_DISTANCE, CFG_W'({$urandom, $urandom})); end
			endcase
			idle_pct = phase_pct[ph % 4];
			for (int n = 0; n < 100; n++)
				pending_q.push_back(rand_query());
			drain();
		end

		$display("checked %0d results (%0d degenerate, %0d inside), %0d mismatches",
			checked, degen_seen, inside_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Run time limit
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
